/* sv/fpa_pkg.sv */
package fpa_pkg;

   localparam int DATA_W = 32;
   localparam int MAG_W  = 2 * DATA_W + 1;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_MIN      = 4'd4,
      CMD_MAX      = 4'd5,
      CMD_CMP      = 4'd6,
      CMD_INC      = 4'd7,
      CMD_DEC      = 4'd8,
      CMD_TO_INT   = 4'd9,
      CMD_FROM_INT = 4'd10
   } cmd_type;

   typedef struct packed {
      logic [3:0]               command;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic                     is_less;
      logic                     is_equal;
      logic                     is_greater;
      logic                     overflow;
      logic                     divide_by_zero;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              ovf;
   } sat_type;

   localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   // saturate a sign and magnitude to the signed word range
   function automatic sat_type sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
      sat_type r;
      if (!neg) begin
         r.ovf   = mag > MAG_W'(MAX_POS);
         r.value = r.ovf ? MAX_POS : mag[DATA_W-1:0];
      end else begin
         r.ovf   = mag > MAG_W'(MIN_NEG);
         r.value = r.ovf ? MIN_NEG : DATA_W'(-mag[DATA_W-1:0]);
      end
      return r;
   endfunction

   // saturate a sum carrying one extra sign bit
   function automatic sat_type sat_sum(input logic [DATA_W:0] s);
      sat_type r;
      r.ovf = s[DATA_W] != s[DATA_W-1];
      if (r.ovf) begin
         r.value = s[DATA_W] ? MIN_NEG : MAX_POS;
      end else begin
         r.value = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

/* sv/fpa_div.sv */
module fpa_div #(
   parameter int FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [fpa_pkg::DATA_W-1:0]      num_mag,
   input  logic [fpa_pkg::DATA_W-1:0]      den_mag,
   output logic [fpa_pkg::DATA_W+FRAC_BITS-1:0] quo,
   output logic [fpa_pkg::DATA_W-1:0]      rem,
   output logic [fpa_pkg::DATA_W-1:0]      den
);
   localparam int W     = fpa_pkg::DATA_W;
   localparam int DEPTH = W + FRAC_BITS;

   logic [W-1:0]     rem_ff [DEPTH];
   logic [DEPTH-1:0] quo_ff [DEPTH];
   logic [DEPTH-1:0] num_ff [DEPTH];
   logic [W-1:0]     den_ff [DEPTH];

   // one quotient bit per stage, restoring
   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      logic [W-1:0]     rem_prev;
      logic [DEPTH-1:0] quo_prev;
      logic [DEPTH-1:0] num_prev;
      logic [W-1:0]     den_prev;
      logic [W:0]       cand;
      logic             fits;
      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign num_prev = {num_mag, {FRAC_BITS{1'b0}}};
         assign den_prev = den_mag;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign num_prev = num_ff[i-1];
         assign den_prev = den_ff[i-1];
      end
      assign cand = {rem_prev, num_prev[DEPTH-1]};
      assign fits = cand >= {1'b0, den_prev};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= fits ? W'(cand - {1'b0, den_prev}) : cand[W-1:0];
            quo_ff[i] <= {quo_prev[DEPTH-2:0], fits};
            num_ff[i] <= {num_prev[DEPTH-2:0], 1'b0};
            den_ff[i] <= den_prev;
         end
      end
   end

   assign quo = quo_ff[DEPTH-1];
   assign rem = rem_ff[DEPTH-1];
   assign den = den_ff[DEPTH-1];

endmodule

/* sv/fixed_point_alu_unit.sv */
// channel   direction  payload              handshake
// req_      in         fpa_pkg::req_type    req_valid / req_stall
// rsp_      out        fpa_pkg::rsp_type    rsp_valid / rsp_stall
//
// one item per cycle unless a stalled result holds the pipeline; the divider
// resolves one quotient bit per pipeline stage
// synchronous active-high reset clears all valid bits; payload is not reset
// a stalled result holds the whole pipeline; req_stall follows it
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fpa_pkg::rsp_type rsp_data
);
   localparam int W     = fpa_pkg::DATA_W;
   localparam int MW    = fpa_pkg::MAG_W;
   localparam int DEPTH = W + FRAC_BITS;

   logic rsp_valid_ff;
   logic en;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // input stage
   logic             s1_valid_ff;
   fpa_pkg::req_type s1_req_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_req_ff <= req_data;
      end
   end

   // decode, simple operations and multiply
   logic signed [W-1:0] a, b;
   logic                an, bn;
   logic [W-1:0]        ma, mb;
   logic                lt;
   fpa_pkg::rsp_type    s2_rsp_in;
   fpa_pkg::sat_type    sv;
   assign a  = s1_req_ff.operand_a;
   assign b  = s1_req_ff.operand_b;
   assign an = a[W-1];
   assign bn = b[W-1];
   assign ma = an ? W'(-a) : W'(a);
   assign mb = bn ? W'(-b) : W'(b);
   assign lt = a < b;

   always_comb begin
      s2_rsp_in = '0;
      sv        = '0;
      case (s1_req_ff.command)
         fpa_pkg::CMD_ADD: sv = fpa_pkg::sat_sum({a[W-1], a} + {b[W-1], b});
         fpa_pkg::CMD_SUB: sv = fpa_pkg::sat_sum({a[W-1], a} - {b[W-1], b});
         fpa_pkg::CMD_INC: sv = fpa_pkg::sat_sum({a[W-1], a} + (W+1)'(1));
         fpa_pkg::CMD_DEC: sv = fpa_pkg::sat_sum({a[W-1], a} - (W+1)'(1));
         fpa_pkg::CMD_MIN: sv.value = lt ? a : b;
         fpa_pkg::CMD_MAX: sv.value = (!lt && a != b) ? a : b;
         fpa_pkg::CMD_TO_INT: sv = fpa_pkg::sat_mag(an, MW'(ma >> FRAC_BITS));
         fpa_pkg::CMD_FROM_INT: sv = fpa_pkg::sat_mag(an, MW'(ma) << FRAC_BITS);
         fpa_pkg::CMD_CMP: begin
            s2_rsp_in.is_less    = lt;
            s2_rsp_in.is_equal   = a == b;
            s2_rsp_in.is_greater = !lt && a != b;
         end
         fpa_pkg::CMD_DIV: s2_rsp_in.divide_by_zero = mb == '0;
         default: sv = '0;
      endcase
      s2_rsp_in.result   = sv.value;
      s2_rsp_in.overflow = sv.ovf;
   end

   logic             s2_valid_ff;
   logic [3:0]       s2_cmd_ff;
   logic             s2_neg_ff;
   logic [W-1:0]     s2_ma_ff, s2_mb_ff;
   logic [2*W-1:0]   s2_prod_ff;
   fpa_pkg::rsp_type s2_rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_cmd_ff  <= s1_req_ff.command;
         s2_neg_ff  <= an ^ bn;
         s2_ma_ff   <= ma;
         s2_mb_ff   <= mb;
         s2_prod_ff <= ma * mb;
         s2_rsp_ff  <= s2_rsp_in;
      end
   end

   // multiply rounding and saturation on entry to the delay line
   fpa_pkg::rsp_type dl_rsp_in;
   fpa_pkg::sat_type mul_sat;
   assign mul_sat = fpa_pkg::sat_mag(s2_neg_ff,
      (MW'(s2_prod_ff) + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
   always_comb begin
      dl_rsp_in = s2_rsp_ff;
      if (s2_cmd_ff == fpa_pkg::CMD_MUL) begin
         dl_rsp_in.result   = mul_sat.value;
         dl_rsp_in.overflow = mul_sat.ovf;
      end
   end

   // side data travels alongside the divider
   logic             dl_valid_ff [DEPTH];
   logic [3:0]       dl_cmd_ff   [DEPTH];
   logic             dl_neg_ff   [DEPTH];
   fpa_pkg::rsp_type dl_rsp_ff   [DEPTH];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            dl_valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         dl_valid_ff[0] <= s2_valid_ff;
         for (int i = 1; i < DEPTH; i++) begin
            dl_valid_ff[i] <= dl_valid_ff[i-1];
         end
      end
      if (en) begin
         dl_cmd_ff[0] <= s2_cmd_ff;
         dl_neg_ff[0] <= s2_neg_ff;
         dl_rsp_ff[0] <= dl_rsp_in;
         for (int i = 1; i < DEPTH; i++) begin
            dl_cmd_ff[i] <= dl_cmd_ff[i-1];
            dl_neg_ff[i] <= dl_neg_ff[i-1];
            dl_rsp_ff[i] <= dl_rsp_ff[i-1];
         end
      end
   end

   logic [DEPTH-1:0] div_quo;
   logic [W-1:0]     div_rem, div_den;
   fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .en      (en),
      .num_mag (s2_ma_ff),
      .den_mag (s2_mb_ff),
      .quo     (div_quo),
      .rem     (div_rem),
      .den     (div_den)
   );

   // divide rounding, saturation and final select
   logic             rnd;
   fpa_pkg::sat_type div_sat;
   fpa_pkg::rsp_type rsp_in;
   assign rnd     = {div_rem, 1'b0} >= {1'b0, div_den};
   assign div_sat = fpa_pkg::sat_mag(dl_neg_ff[DEPTH-1], MW'(div_quo) + MW'(rnd));
   always_comb begin
      rsp_in = dl_rsp_ff[DEPTH-1];
      if (dl_cmd_ff[DEPTH-1] == fpa_pkg::CMD_DIV && !rsp_in.divide_by_zero) begin
         rsp_in.result   = div_sat.value;
         rsp_in.overflow = div_sat.ovf;
      end
   end

   fpa_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dl_valid_ff[DEPTH-1];
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.is_less, rsp_data.is_equal, rsp_data.is_greater}))
      else $error("more than one compare flag set");
   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> !rsp_data.overflow && rsp_data.result == '0)
      else $error("divide by zero with nonzero result or overflow");
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output stalled");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAC    = 8;
   localparam int LATENCY = fpa_pkg::DATA_W + FRAC + 3;
   localparam int WATCHDOG_LIMIT = 20000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   fpa_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   fpa_pkg::rsp_type rsp_data;

   fixed_point_alu_unit #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   fpa_pkg::rsp_type alu_expected_q[$];
   int      error_count;
   int      items_sent;
   int      results_seen;
   int      req_idle_pct;
   int      rsp_idle_pct;
   int      quiet_cycles;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // saturate a sign and a wide magnitude to the word range
   function automatic logic [fpa_pkg::DATA_W-1:0] clamp_mag(input logic neg,
                                                            input logic [127:0] mag,
                                                            inout logic ovf);
      if (!neg) begin
         if (mag > 128'(fpa_pkg::MAX_POS)) begin
            ovf = 1'b1;
            return fpa_pkg::MAX_POS;
         end
         return mag[fpa_pkg::DATA_W-1:0];
      end
      if (mag > 128'(fpa_pkg::MIN_NEG)) begin
         ovf = 1'b1;
         return fpa_pkg::MIN_NEG;
      end
      return fpa_pkg::DATA_W'(-mag[fpa_pkg::DATA_W-1:0]);
   endfunction

   // exact fixed-point arithmetic for one command
   function automatic fpa_pkg::rsp_type alu_predict(input fpa_pkg::req_type rq);
      fpa_pkg::rsp_type r;
      logic signed [fpa_pkg::DATA_W-1:0] a, b;
      logic signed [fpa_pkg::DATA_W+1:0] wsum;
      logic [127:0] ma, mb, prod, quo, rem;
      logic ovf;
      logic neg;
      a = rq.operand_a;
      b = rq.operand_b;
      ma = a[fpa_pkg::DATA_W-1] ? 128'(-{{1{a[fpa_pkg::DATA_W-1]}}, a}) : 128'(a);
      mb = b[fpa_pkg::DATA_W-1] ? 128'(-{{1{b[fpa_pkg::DATA_W-1]}}, b}) : 128'(b);
      ma = ma & ((128'd1 << (fpa_pkg::DATA_W + 1)) - 1);
      mb = mb & ((128'd1 << (fpa_pkg::DATA_W + 1)) - 1);
      neg = a[fpa_pkg::DATA_W-1] ^ b[fpa_pkg::DATA_W-1];
      r = '0;
      ovf = 1'b0;
      case (rq.command)
         fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
            case (rq.command)
               fpa_pkg::CMD_ADD: wsum = a + b;
               fpa_pkg::CMD_SUB: wsum = a - b;
               fpa_pkg::CMD_INC: wsum = a + 1;
               default: wsum = a - 1;
            endcase
            if (wsum > $signed({2'b00, fpa_pkg::MAX_POS})) begin
               ovf = 1'b1;
               r.result = fpa_pkg::MAX_POS;
            end else if (wsum < $signed({2'b11, fpa_pkg::MIN_NEG})) begin
               ovf = 1'b1;
               r.result = fpa_pkg::MIN_NEG;
            end else begin
               r.result = wsum[fpa_pkg::DATA_W-1:0];
            end
         end
         fpa_pkg::CMD_MUL: begin
            prod = ((ma * mb) + (128'd1 << (FRAC - 1))) >> FRAC;
            r.result = clamp_mag(neg, prod, ovf);
         end
         fpa_pkg::CMD_DIV: begin
            if (mb == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               quo = (ma << FRAC) / mb;
               rem = (ma << FRAC) % mb;
               if (rem >= mb - rem) quo = quo + 1;
               r.result = clamp_mag(neg, quo, ovf);
            end
         end
         fpa_pkg::CMD_MIN: r.result = (a < b) ? a : b;
         fpa_pkg::CMD_MAX: r.result = (a > b) ? a : b;
         fpa_pkg::CMD_CMP: begin
            r.is_less    = a < b;
            r.is_equal   = a == b;
            r.is_greater = a > b;
         end
         fpa_pkg::CMD_TO_INT: r.result = clamp_mag(a[fpa_pkg::DATA_W-1], ma >> FRAC, ovf);
         fpa_pkg::CMD_FROM_INT: r.result = clamp_mag(a[fpa_pkg::DATA_W-1], ma << FRAC, ovf);
         default: r = '0;
      endcase
      r.overflow = ovf;
      return r;
   endfunction

   // send one item, holding it until accepted
   task automatic send_item(input logic [3:0] cmd, input logic [fpa_pkg::DATA_W-1:0] a,
                            input logic [fpa_pkg::DATA_W-1:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, operand_a: a, operand_b: b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         alu_expected_q.push_back(alu_predict(req_data));
         items_sent++;
      end
   end

   // check each result against the oldest prediction
   always @(posedge clock) begin
      fpa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (alu_expected_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            error_count++;
         end else begin
            want = alu_expected_q.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   // random result stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic logic [fpa_pkg::DATA_W-1:0] rand_operand();
      case ($urandom_range(5))
         0: return fpa_pkg::MAX_POS - $urandom_range(2);
         1: return fpa_pkg::MIN_NEG + $urandom_range(2);
         2: return fpa_pkg::DATA_W'($signed($urandom_range(4096)) - 2048);
         3: return fpa_pkg::DATA_W'($signed($urandom_range(1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   // extremes of every operation, including rounding halves and saturation
   task automatic test_directed();
      send_item(fpa_pkg::CMD_ADD, fpa_pkg::MAX_POS, 32'd1);
      send_item(fpa_pkg::CMD_ADD, fpa_pkg::MIN_NEG, '1);
      send_item(fpa_pkg::CMD_SUB, fpa_pkg::MIN_NEG, 32'd1);
      send_item(fpa_pkg::CMD_SUB, fpa_pkg::MAX_POS, '1);
      send_item(fpa_pkg::CMD_MUL, 32'd384, 32'd1);
      send_item(fpa_pkg::CMD_MUL, -32'sd384, 32'd1);
      send_item(fpa_pkg::CMD_MUL, fpa_pkg::MIN_NEG, fpa_pkg::MIN_NEG);
      send_item(fpa_pkg::CMD_MUL, fpa_pkg::MAX_POS, fpa_pkg::MIN_NEG);
      send_item(fpa_pkg::CMD_DIV, 32'd1, 32'd512);
      send_item(fpa_pkg::CMD_DIV, -32'sd1, 32'd512);
      send_item(fpa_pkg::CMD_DIV, fpa_pkg::MAX_POS, 32'd0);
      send_item(fpa_pkg::CMD_DIV, fpa_pkg::MIN_NEG, 32'd1);
      send_item(fpa_pkg::CMD_DIV, fpa_pkg::MIN_NEG, fpa_pkg::MIN_NEG);
      send_item(fpa_pkg::CMD_MIN, fpa_pkg::MIN_NEG, fpa_pkg::MAX_POS);
      send_item(fpa_pkg::CMD_MAX, fpa_pkg::MIN_NEG, fpa_pkg::MAX_POS);
      send_item(fpa_pkg::CMD_CMP, 32'd5, 32'd5);
      send_item(fpa_pkg::CMD_CMP, fpa_pkg::MIN_NEG, fpa_pkg::MAX_POS);
      send_item(fpa_pkg::CMD_CMP, fpa_pkg::MAX_POS, fpa_pkg::MIN_NEG);
      send_item(fpa_pkg::CMD_INC, fpa_pkg::MAX_POS, 32'd0);
      send_item(fpa_pkg::CMD_DEC, fpa_pkg::MIN_NEG, 32'd0);
      send_item(fpa_pkg::CMD_TO_INT, -32'sd257, 32'd0);
      send_item(fpa_pkg::CMD_TO_INT, fpa_pkg::MIN_NEG, 32'd0);
      send_item(fpa_pkg::CMD_FROM_INT, 32'h0080_0000, 32'd0);
      send_item(fpa_pkg::CMD_FROM_INT, fpa_pkg::MIN_NEG, 32'd0);
      send_item(4'd15, '1, '1);
   endtask

   // random commands and operands under one idling profile
   task automatic test_random(input int count, input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) begin
         send_item(($urandom_range(15) == 0) ? 4'($urandom_range(15, 11))
                                              : 4'($urandom_range(10)),
                   rand_operand(), rand_operand());
      end
   endtask

   initial begin
      error_count  = 0;
      items_sent   = 0;
      results_seen = 0;
      quiet_cycles = 0;
      req_idle_pct = 27;
      rsp_idle_pct = 76;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(425, 27, 76);
      test_random(425, 76, 27);
      test_random(425, 0, 0);
      req_valid <= 1'b0;

      while (alu_expected_q.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (alu_expected_q.size() != 0) error_count++;

      $display("sent %0d items over all commands and idling profiles, checked %0d results",
               items_sent, results_seen);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
